// ===== rtl/lattice_aggregation_walker_top_macros.svh =====
// assertion macros shared by the checker of the aggregation walker
// no dependencies; take in with a plain include
`ifndef LATTICE_AGGREGATION_WALKER_TOP_MACROS_SVH
`define LATTICE_AGGREGATION_WALKER_TOP_MACROS_SVH

// clocked assertion, off while reset is low
`define LAW_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds while reset is low
`define LAW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/law_pkg.sv =====
// types and codes of the lattice aggregation walker
// no dependencies
package law_pkg;

    localparam int CNT_W  = 17;
    localparam int CELL_W = 3;
    localparam int SIZE_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CELL_W-1:0] CELL_EMPTY = 3'd0;
    localparam logic [CELL_W-1:0] CELL_SEED  = 3'd5;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam logic [1:0] SIDE_TOP    = 2'd0;
    localparam logic [1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [1:0] SIDE_BOTTOM = 2'd2;
    localparam logic [1:0] SIDE_LEFT   = 2'd3;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNERS_MODE   = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_SEED,
        S_IDLE,
        S_SPAWN,
        S_NB0,
        S_NB1,
        S_NB2,
        S_NB3,
        S_DECIDE,
        S_HIT
    } t_state;

    typedef enum logic {
        OP_DEC,
        OP_INC
    } t_coord_op;

    typedef struct packed {
        logic       action;
        logic [1:0] spawn_side;
        logic [7:0] spawn_offset;
        logic [1:0] move_dir;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       hit_x;
        logic [7:0]       hit_y;
        logic [1:0]       hit_band;
        logic [CNT_W-1:0] particles_left;
        logic             finished;
    } t_out_item;

endpackage

// ===== rtl/law_stream_if.sv =====
// valid/ready stream channel with a typed payload
// no dependencies; payload type given per instance
interface law_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/law_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module law_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/law_step_unit.sv =====
// shared coordinate step and count compare unit of the walker
// depends on law_pkg
module law_step_unit import law_pkg::*; #(
    parameter int CW = 8
) (
    input  t_coord_op        i_op,
    input  logic [CW-1:0]    i_coord,
    input  logic [CW-1:0]    i_coord_max,
    input  logic [CNT_W-1:0] i_count,
    input  logic [CNT_W-1:0] i_thresh,
    output logic [CW-1:0]    o_coord_next,
    output logic             o_coord_ok,
    output logic             o_count_lt
);
    always_comb begin
        case (i_op)
            OP_DEC: begin
                o_coord_next = i_coord - CW'(1);
                o_coord_ok   = (i_coord != '0);
            end
            OP_INC: begin
                o_coord_next = i_coord + CW'(1);
                o_coord_ok   = (i_coord < i_coord_max);
            end
            default: begin
                o_coord_next = i_coord;
                o_coord_ok   = 1'b0;
            end
        endcase
    end

    assign o_count_lt = (i_count < i_thresh);
endmodule

// ===== rtl/lattice_aggregation_walker_top.sv =====
// lattice aggregation walker: random walkers stick to a growing cluster on a grid
// depends on law_pkg, law_stream_if, law_ram, law_step_unit
// tick request: spawn, four neighbour reads through the single read port (NB0 to NB3),
//   decide, plus a wait on the sink with a hit; a tick after the run ends is dropped at spawn
// start request and reset: clearing pass over every cell of the grid store
//   plus one seed write; synchronous active-low reset restores the control register defaults
module lattice_aggregation_walker_top import law_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    law_stream_if.sink            i_req,
    law_stream_if.source          o_rsp
);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int XW1   = XW + 1;
    localparam int YW1   = YW + 1;
    localparam int CW    = (XW > YW) ? XW : YW;
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    // seed spot of the reset pass, from the reset grid size
    localparam int SEED_X0 = ((MAX_WIDTH < 256) ? MAX_WIDTH : 256) / 2;
    localparam int SEED_Y0 = ((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256) / 2;

    // configuration registers
    logic [SIZE_W-1:0] r_grid_width;
    logic [SIZE_W-1:0] r_grid_height;
    logic [CNT_W-1:0]  r_lim;
    logic              r_corners;

    // sequencer and walker state
    t_state           r_state,  n_state;
    logic [AW-1:0]    r_clr,    n_clr;
    logic [AW-1:0]    r_seed,   n_seed;
    t_in_item         r_req,    n_req;
    logic [XW-1:0]    r_x,      n_x;
    logic [YW-1:0]    r_y,      n_y;
    logic             r_active, n_active;
    logic [CNT_W-1:0] r_stuck,  n_stuck;
    logic             r_hit,    n_hit;
    logic             r_nb_ok,  n_nb_ok;
    logic [2:0]       r_lt,     n_lt;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out,    n_out;

    // effective grid size
    logic [XW1-1:0] eff_w;
    logic [YW1-1:0] eff_h;
    logic [XW-1:0]  wm1;
    logic [YW-1:0]  hm1;
    logic [XW-1:0]  seed_x;
    logic [YW-1:0]  seed_y;
    logic [XW-1:0]  spawn_x;
    logic [YW-1:0]  spawn_y;
    logic [XW-1:0]  sat_x;
    logic [YW-1:0]  sat_y;

    // ram ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    // shared unit ports
    t_coord_op        unit_op;
    logic [CW-1:0]    unit_coord;
    logic [CW-1:0]    unit_max;
    logic [CNT_W-1:0] unit_thresh;
    logic [CW-1:0]    unit_next;
    logic             unit_ok;
    logic             unit_lt;

    logic [CNT_W-1:0] quarter;
    logic [CNT_W-1:0] stuck_inc;
    logic             nb_occupied;
    logic             hit_all;
    logic [1:0]       band;
    logic             out_free;

    // config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= SIZE_W'(256);
            r_grid_height <= SIZE_W'(256);
            r_lim         <= CNT_W'(6554);
            r_corners     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_WIDTH:     r_grid_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_GRID_HEIGHT:    r_grid_height <= i_cfg_data[SIZE_W-1:0];
                CFG_PARTICLE_LIMIT: r_lim         <= i_cfg_data[CNT_W-1:0];
                CFG_CORNERS_MODE:   r_corners     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // width and height clamped to 1..max
    always_comb begin
        if (r_grid_width == '0) begin
            eff_w = XW1'(1);
        end else if (32'(r_grid_width) > MAX_WIDTH) begin
            eff_w = XW1'(MAX_WIDTH);
        end else begin
            eff_w = XW1'(r_grid_width);
        end
        if (r_grid_height == '0) begin
            eff_h = YW1'(1);
        end else if (32'(r_grid_height) > MAX_HEIGHT) begin
            eff_h = YW1'(MAX_HEIGHT);
        end else begin
            eff_h = YW1'(r_grid_height);
        end
    end

    assign wm1    = XW'(eff_w - XW1'(1));
    assign hm1    = YW'(eff_h - YW1'(1));
    assign seed_x = XW'(eff_w >> 1);
    assign seed_y = YW'(eff_h >> 1);

    // spawn offset saturated to the last cell of the edge
    assign sat_x = (32'(r_req.spawn_offset) > 32'(wm1)) ? wm1 : XW'(r_req.spawn_offset);
    assign sat_y = (32'(r_req.spawn_offset) > 32'(hm1)) ? hm1 : YW'(r_req.spawn_offset);

    // spawn position on an edge, or on a corner in corners mode
    always_comb begin
        spawn_x = '0;
        spawn_y = '0;
        case (r_req.spawn_side)
            SIDE_TOP: begin
                spawn_x = r_corners ? '0 : sat_x;
                spawn_y = '0;
            end
            SIDE_RIGHT: begin
                spawn_x = wm1;
                spawn_y = r_corners ? '0 : sat_y;
            end
            SIDE_BOTTOM: begin
                spawn_x = r_corners ? wm1 : sat_x;
                spawn_y = hm1;
            end
            default: begin
                spawn_x = '0;
                spawn_y = r_corners ? hm1 : sat_y;
            end
        endcase
    end

    assign quarter     = r_lim >> 2;
    assign stuck_inc   = r_stuck + CNT_W'(1);
    // data of the read issued one state earlier
    assign nb_occupied = r_nb_ok && (ram_rdata != CELL_EMPTY);
    assign hit_all     = r_hit || nb_occupied;
    assign out_free    = !r_out_valid || o_rsp.ready;

    // color band from the quarter compares, first one below wins
    always_comb begin
        if (r_lt[0]) begin
            band = 2'd0;
        end else if (r_lt[1]) begin
            band = 2'd1;
        end else if (r_lt[2]) begin
            band = 2'd2;
        end else begin
            band = 2'd3;
        end
    end

    // sequencer: next state and datapath controls
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_seed      = r_seed;
        n_req       = r_req;
        n_x         = r_x;
        n_y         = r_y;
        n_active    = r_active;
        n_stuck     = r_stuck;
        n_hit       = r_hit;
        n_nb_ok     = r_nb_ok;
        n_lt        = r_lt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;

        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = CELL_EMPTY;
        ram_raddr   = '0;

        unit_op     = OP_DEC;
        unit_coord  = CW'(r_x);
        unit_max    = CW'(wm1);
        unit_thresh = r_lim;

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = CELL_EMPTY;
                n_clr     = r_clr + AW'(1);
                if (&r_clr) begin
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                ram_we    = 1'b1;
                ram_waddr = r_seed;
                ram_wdata = CELL_SEED;
                n_x       = '0;
                n_y       = '0;
                n_active  = 1'b0;
                n_stuck   = '0;
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req = i_req.data;
                    if (i_req.data.action == ACT_START) begin
                        // seed spot taken from the grid size at the start request
                        n_seed  = {seed_y, seed_x};
                        n_clr   = '0;
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_SPAWN;
                    end
                end
            end
            S_SPAWN: begin
                // run over: tick is dropped
                unit_thresh = r_lim;
                if (!unit_lt) begin
                    n_state = S_IDLE;
                end else begin
                    if (r_active) begin
                        // grid may have shrunk since the last step
                        n_x = (r_x > wm1) ? wm1 : r_x;
                        n_y = (r_y > hm1) ? hm1 : r_y;
                    end else begin
                        n_x = spawn_x;
                        n_y = spawn_y;
                    end
                    n_active = 1'b1;
                    n_state  = S_NB0;
                end
            end
            S_NB0: begin
                // left neighbour
                unit_op     = OP_DEC;
                unit_coord  = CW'(r_x);
                unit_max    = CW'(wm1);
                ram_raddr   = {r_y, XW'(unit_next)};
                n_nb_ok     = unit_ok;
                n_hit       = 1'b0;
                unit_thresh = quarter;
                n_lt[0]     = unit_lt;
                n_state     = S_NB1;
            end
            S_NB1: begin
                // right neighbour
                unit_op     = OP_INC;
                unit_coord  = CW'(r_x);
                unit_max    = CW'(wm1);
                ram_raddr   = {r_y, XW'(unit_next)};
                n_nb_ok     = unit_ok;
                n_hit       = hit_all;
                unit_thresh = r_lim >> 1;
                n_lt[1]     = unit_lt;
                n_state     = S_NB2;
            end
            S_NB2: begin
                // upper neighbour
                unit_op     = OP_DEC;
                unit_coord  = CW'(r_y);
                unit_max    = CW'(hm1);
                ram_raddr   = {YW'(unit_next), r_x};
                n_nb_ok     = unit_ok;
                n_hit       = hit_all;
                unit_thresh = quarter + (quarter << 1);
                n_lt[2]     = unit_lt;
                n_state     = S_NB3;
            end
            S_NB3: begin
                // lower neighbour
                unit_op    = OP_INC;
                unit_coord = CW'(r_y);
                unit_max   = CW'(hm1);
                ram_raddr  = {YW'(unit_next), r_x};
                n_nb_ok    = unit_ok;
                n_hit      = hit_all;
                n_state    = S_DECIDE;
            end
            S_DECIDE: begin
                // the step unit now does the move, kept only when nothing was hit
                unit_op    = (r_req.move_dir == DIR_LEFT || r_req.move_dir == DIR_UP)
                             ? OP_DEC : OP_INC;
                if (r_req.move_dir == DIR_LEFT || r_req.move_dir == DIR_RIGHT) begin
                    unit_coord = CW'(r_x);
                    unit_max   = CW'(wm1);
                end else begin
                    unit_coord = CW'(r_y);
                    unit_max   = CW'(hm1);
                end
                n_hit = hit_all;
                if (hit_all) begin
                    n_state = S_HIT;
                end else begin
                    if (unit_ok) begin
                        if (r_req.move_dir == DIR_LEFT || r_req.move_dir == DIR_RIGHT) begin
                            n_x = XW'(unit_next);
                        end else begin
                            n_y = YW'(unit_next);
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            S_HIT: begin
                // wait for the result register to drain, then stick
                if (out_free) begin
                    ram_we               = 1'b1;
                    ram_waddr            = {r_y, r_x};
                    ram_wdata            = CELL_W'(band) + CELL_W'(1);
                    n_stuck              = stuck_inc;
                    n_active             = 1'b0;
                    n_out_valid          = 1'b1;
                    n_out.hit_x          = 8'(r_x);
                    n_out.hit_y          = 8'(r_y);
                    n_out.hit_band       = band;
                    n_out.particles_left = r_lim - stuck_inc;
                    n_out.finished       = (stuck_inc == r_lim);
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_seed      <= {YW'(SEED_Y0), XW'(SEED_X0)};
            r_x         <= '0;
            r_y         <= '0;
            r_active    <= 1'b0;
            r_stuck     <= '0;
            r_hit       <= 1'b0;
            r_nb_ok     <= 1'b0;
            r_lt        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr       <= n_clr;
            r_seed      <= n_seed;
            r_x         <= n_x;
            r_y         <= n_y;
            r_active    <= n_active;
            r_stuck     <= n_stuck;
            r_hit       <= n_hit;
            r_nb_ok     <= n_nb_ok;
            r_lt        <= n_lt;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_out <= n_out;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // grid store, one cell per {row, column}
    law_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // neighbour addresses, moves and count compares
    law_step_unit #(
        .CW (CW)
    ) u_step (
        .i_op         (unit_op),
        .i_coord      (unit_coord),
        .i_coord_max  (unit_max),
        .i_count      (r_stuck),
        .i_thresh     (unit_thresh),
        .o_coord_next (unit_next),
        .o_coord_ok   (unit_ok),
        .o_count_lt   (unit_lt)
    );
endmodule

// ===== rtl/law_checker.sv =====
// port level checks of the lattice aggregation walker, bound to the top level
// depends on law_pkg and lattice_aggregation_walker_top_macros.svh
`include "lattice_aggregation_walker_top_macros.svh"

module law_checker import law_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_out_finished,
    input logic [CNT_W-1:0] i_out_left
);
    // busy in the cycle after every request
    `LAW_ASSERT_CLK(a_busy_after_req, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready, "ready right after a request")

    // reset always starts the clearing pass
    `LAW_ASSERT_ALWAYS(a_clear_after_reset, i_clk, !i_rst_n |=> !i_in_ready, "ready right after reset")

    // a result waits until it is taken
    `LAW_ASSERT_CLK(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")

    // the last particle leaves nothing to stick
    `LAW_ASSERT_CLK(a_finish_left, i_clk, i_rst_n, i_out_valid && i_out_finished |-> i_out_left == '0, "finished with particles left")
endmodule

bind lattice_aggregation_walker_top law_checker u_law_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_out_finished (o_rsp.data.finished),
    .i_out_left     (o_rsp.data.particles_left)
);

// ===== tb/sv/lattice_aggregation_walker_top_tb.sv =====
// self-checking bench for lattice_aggregation_walker_top: a grid predictor in a small
// scoreboard class, bursty request driver, stalling result sink and an idle watchdog
// depends on law_pkg, law_stream_if and the rtl of the walker
module lattice_aggregation_walker_top_tb;
    import law_pkg::*;

    localparam int MAX_W        = 256;
    localparam int MAX_H        = 256;
    localparam int GRID_CELLS   = MAX_W * MAX_H;
    localparam int LIMIT_MAX    = 65536;
    // a clearing pass writes all 2**16 cells plus the seed; allow several of them
    localparam int IDLE_LIMIT   = 270000;
    // enough to let a tick still in flight finish
    localparam int SETTLE_TICKS = 16;
    localparam int END_TICKS    = 40;
    localparam int LIVE_TARGET  = 1750;
    localparam int HIT_TARGET   = 48;

    // predictor of the grid plus the queue of hits still due from the block
    class walker_scoreboard;
        bit [SIZE_W-1:0] cfg_width;
        bit [SIZE_W-1:0] cfg_height;
        bit [CNT_W-1:0]  cfg_limit;
        bit              cfg_corners;
        bit [CELL_W-1:0] cells [GRID_CELLS];
        int unsigned     pos_x;
        int unsigned     pos_y;
        bit              roaming;
        int unsigned     stuck_total;
        t_out_item       hits_due [$];
        int unsigned     hits_made;
        int unsigned     fails;

        function new();
            cfg_width   = 9'(MAX_W);
            cfg_height  = 9'(MAX_H);
            cfg_limit   = 17'd6554;
            cfg_corners = 1'b0;
            hits_made   = 0;
            fails       = 0;
            wipe_grid();
        endfunction

        function int unsigned used_width();
            int unsigned v;
            v = cfg_width;
            if (v < 1) v = 1;
            if (v > MAX_W) v = MAX_W;
            return v;
        endfunction

        function int unsigned used_height();
            int unsigned v;
            v = cfg_height;
            if (v < 1) v = 1;
            if (v > MAX_H) v = MAX_H;
            return v;
        endfunction

        function void wipe_grid();
            foreach (cells[i]) cells[i] = CELL_EMPTY;
            cells[(used_height() / 2) * MAX_W + used_width() / 2] = CELL_SEED;
            pos_x       = 0;
            pos_y       = 0;
            roaming     = 1'b0;
            stuck_total = 0;
        endfunction

        function bit occupied(int unsigned x, int unsigned y);
            return cells[y * MAX_W + x] != CELL_EMPTY;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_GRID_WIDTH:     cfg_width   = value[SIZE_W-1:0];
                CFG_GRID_HEIGHT:    cfg_height  = value[SIZE_W-1:0];
                CFG_PARTICLE_LIMIT: cfg_limit   = value[CNT_W-1:0];
                CFG_CORNERS_MODE:   cfg_corners = value[0];
                default: ;
            endcase
        endfunction

        // returns 0 for a tick that the block drops because the run has ended
        function bit predict_request(t_in_item it);
            int unsigned w, h, ox, oy, x, y, lim, band;
            bit          hit;
            t_out_item   res;
            w = used_width();
            h = used_height();
            if (it.action == ACT_START) begin
                wipe_grid();
                return 1'b1;
            end
            if (stuck_total >= cfg_limit) return 1'b0;
            if (!roaming) begin
                ox = (it.spawn_offset > w - 1) ? w - 1 : it.spawn_offset;
                oy = (it.spawn_offset > h - 1) ? h - 1 : it.spawn_offset;
                if (!cfg_corners) begin
                    case (it.spawn_side)
                        SIDE_TOP:    begin pos_x = ox;    pos_y = 0;     end
                        SIDE_RIGHT:  begin pos_x = w - 1; pos_y = oy;    end
                        SIDE_BOTTOM: begin pos_x = ox;    pos_y = h - 1; end
                        default:     begin pos_x = 0;     pos_y = oy;    end
                    endcase
                end else begin
                    case (it.spawn_side)
                        SIDE_TOP:    begin pos_x = 0;     pos_y = 0;     end
                        SIDE_RIGHT:  begin pos_x = w - 1; pos_y = 0;     end
                        SIDE_BOTTOM: begin pos_x = w - 1; pos_y = h - 1; end
                        default:     begin pos_x = 0;     pos_y = h - 1; end
                    endcase
                end
                roaming = 1'b1;
            end
            // a walker left over from a larger grid is pulled inside first
            if (pos_x > w - 1) pos_x = w - 1;
            if (pos_y > h - 1) pos_y = h - 1;
            x = pos_x;
            y = pos_y;
            hit = (x > 0 && occupied(x - 1, y)) || (x < w - 1 && occupied(x + 1, y))
               || (y > 0 && occupied(x, y - 1)) || (y < h - 1 && occupied(x, y + 1));
            if (hit) begin
                lim = cfg_limit;
                if (stuck_total < lim / 4) band = 0;
                else if (stuck_total < lim / 2) band = 1;
                else if (stuck_total < (lim / 4) * 3) band = 2;
                else band = 3;
                cells[y * MAX_W + x] = 3'(band + 1);
                stuck_total++;
                roaming            = 1'b0;
                res.hit_x          = 8'(x);
                res.hit_y          = 8'(y);
                res.hit_band       = 2'(band);
                res.particles_left = 17'(lim - stuck_total);
                res.finished       = (stuck_total == lim);
                hits_due.push_back(res);
                hits_made++;
                return 1'b1;
            end
            case (it.move_dir)
                DIR_LEFT:  if (x != 0) pos_x = x - 1;
                DIR_RIGHT: if (x < w - 1) pos_x = x + 1;
                DIR_UP:    if (y != 0) pos_y = y - 1;
                default:   if (y < h - 1) pos_y = y + 1;
            endcase
            return 1'b1;
        endfunction

        function void check_hit(t_out_item got);
            t_out_item want;
            if (hits_due.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected hit: x=%0d y=%0d band=%0d left=%0d fin=%0d",
                             got.hit_x, got.hit_y, got.hit_band, got.particles_left,
                             got.finished);
                return;
            end
            want = hits_due.pop_front();
            if (got.hit_x !== want.hit_x || got.hit_y !== want.hit_y
                || got.hit_band !== want.hit_band
                || got.particles_left !== want.particles_left
                || got.finished !== want.finished) begin
                fails++;
                if (fails <= 10)
                    $display({"hit mismatch: expected x=%0d y=%0d band=%0d left=%0d fin=%0d,",
                              " got x=%0d y=%0d band=%0d left=%0d fin=%0d"},
                             want.hit_x, want.hit_y, want.hit_band, want.particles_left,
                             want.finished, got.hit_x, got.hit_y, got.hit_band,
                             got.particles_left, got.finished);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    law_stream_if #(.T(t_in_item))  req_if ();
    law_stream_if #(.T(t_out_item)) rsp_if ();

    lattice_aggregation_walker_top #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    walker_scoreboard sb;

    // sender pacing: bursts with gaps, or steady back-to-back for a whole phase
    int unsigned burst_left = 0;
    bit          steady     = 1'b0;
    // ticks that did something, start requests included
    int unsigned live_items = 0;

    // receiver pacing state, owned by the sink process
    int unsigned rx_span = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_hold = 0;

    initial clk = 1'b0;
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic t_in_item request_of(logic act, logic [1:0] side, logic [7:0] off,
                                            logic [1:0] dir);
        t_in_item it;
        it.action       = act;
        it.spawn_side   = side;
        it.spawn_offset = off;
        it.move_dir     = dir;
        return it;
    endfunction

    // random tick; offsets mix the extremes, full range and values up to the edge length
    function automatic t_in_item random_tick();
        int unsigned r, span;
        logic [7:0]  off;
        r = $urandom_range(0, 7);
        span = sb.used_width() > sb.used_height() ? sb.used_width() : sb.used_height();
        if (span > 255) span = 255;
        if (r == 0) off = 8'd0;
        else if (r == 1) off = 8'd255;
        else if (r <= 4) off = 8'($urandom_range(0, 255));
        else off = 8'($urandom_range(0, span));
        return request_of(ACT_TICK, 2'($urandom_range(0, 3)), off, 2'($urandom_range(0, 3)));
    endfunction

    // mostly small grids so that walkers meet the cluster soon, now and then the extremes
    function automatic int unsigned pick_size();
        int unsigned r, v;
        r = $urandom_range(0, 9);
        if (r <= 5) v = $urandom_range(1, 12);
        else if (r <= 7) v = $urandom_range(13, 40);
        else if (r == 8) v = $urandom_range(0, 2);
        else begin
            case ($urandom_range(0, 4))
                0:       v = 255;
                1:       v = 256;
                2:       v = 257;
                3:       v = 511;
                default: v = $urandom_range(41, 511);
            endcase
        end
        return v;
    endfunction

    // register write, issued while no request is held on the channel
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        sb.apply_reg(idx, CFG_DATA_W'(value));
        @(negedge clk) i_cfg_we <= 1'b0;
    endtask

    // one request: optional gap first, then hold valid until the block takes it
    task automatic issue(input t_in_item it);
        int unsigned gap;
        if (!steady) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30)
                                                  : $urandom_range(0, 4);
                repeat (gap) @(negedge clk) req_if.valid <= 1'b0;
            end
            burst_left--;
        end
        @(negedge clk);
        req_if.valid <= 1'b1;
        req_if.data  <= it;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        if (sb.predict_request(it)) live_items++;
    endtask

    // drop valid, wait for every due hit, then let a tick still in flight finish
    task automatic settle(input int unsigned extra);
        @(negedge clk) req_if.valid <= 1'b0;
        while (sb.hits_due.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // result sink with a stall pattern of its own: open, random, or long holds
    always @(negedge clk) begin
        if (rx_span == 0) begin
            rx_span = $urandom_range(16, 160);
            rx_mode = $urandom_range(0, 2);
        end else begin
            rx_span--;
        end
        if (rx_hold != 0) begin
            rx_hold--;
            rsp_if.ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: rsp_if.ready <= 1'b1;
                1: rsp_if.ready <= ($urandom_range(0, 2) != 0);
                default: begin
                    rsp_if.ready <= 1'b1;
                    if ($urandom_range(0, 11) == 0) rx_hold = $urandom_range(1, 15);
                end
            endcase
        end
    end

    // every accepted hit goes against the oldest prediction
    always @(posedge clk) begin
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            sb.check_hit(rsp_if.data);
    end

    // ends the run when nothing moves on either channel for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1)
                || (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int unsigned n, k, lim, starts_left, size_w, size_h;
        sb           = new();
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        repeat (6) @(negedge clk);
        i_rst_n <= 1'b1;

        // ---- directed part on a 5x5 grid, seed lands at (2,2) ----
        cfg_write(CFG_GRID_WIDTH, 5);
        cfg_write(CFG_GRID_HEIGHT, 5);
        cfg_write(CFG_PARTICLE_LIMIT, 3);
        cfg_write(CFG_CORNERS_MODE, 0);
        issue(request_of(ACT_START, SIDE_LEFT, 8'hff, DIR_DOWN));
        // spawn top-left, bump into the top and left borders, then walk to just above the seed
        issue(request_of(ACT_TICK, SIDE_TOP, 8'd0, DIR_UP));
        issue(request_of(ACT_TICK, SIDE_TOP, 8'd0, DIR_LEFT));
        issue(request_of(ACT_TICK, SIDE_TOP, 8'd0, DIR_RIGHT));
        issue(request_of(ACT_TICK, SIDE_TOP, 8'd0, DIR_DOWN));
        issue(request_of(ACT_TICK, SIDE_TOP, 8'd0, DIR_RIGHT));
        // above the seed: first hit
        issue(request_of(ACT_TICK, SIDE_TOP, 8'd0, DIR_LEFT));
        // right edge with an offset past the edge length, saturates to the last row
        issue(request_of(ACT_TICK, SIDE_RIGHT, 8'd255, DIR_UP));
        issue(request_of(ACT_TICK, SIDE_RIGHT, 8'd255, DIR_LEFT));
        issue(request_of(ACT_TICK, SIDE_RIGHT, 8'd255, DIR_UP));
        issue(request_of(ACT_TICK, SIDE_RIGHT, 8'd255, DIR_DOWN));
        // bottom edge, third hit reaches the limit
        issue(request_of(ACT_TICK, SIDE_BOTTOM, 8'd2, DIR_UP));
        issue(request_of(ACT_TICK, SIDE_BOTTOM, 8'd2, DIR_UP));
        // run ended: dropped
        issue(request_of(ACT_TICK, SIDE_LEFT, 8'd1, DIR_DOWN));
        settle(SETTLE_TICKS);

        // corners mode, limit at its top
        cfg_write(CFG_PARTICLE_LIMIT, LIMIT_MAX);
        cfg_write(CFG_CORNERS_MODE, 1);
        issue(request_of(ACT_TICK, SIDE_RIGHT, 8'd0, DIR_DOWN));
        issue(request_of(ACT_TICK, SIDE_RIGHT, 8'd0, DIR_LEFT));
        issue(request_of(ACT_TICK, SIDE_RIGHT, 8'd0, DIR_LEFT));
        issue(request_of(ACT_TICK, SIDE_BOTTOM, 8'h80, DIR_RIGHT));
        issue(request_of(ACT_TICK, SIDE_BOTTOM, 8'h80, DIR_DOWN));
        settle(SETTLE_TICKS);

        // shrink under an active walker so that it gets pulled inside
        cfg_write(CFG_GRID_WIDTH, 2);
        cfg_write(CFG_GRID_HEIGHT, 9);
        issue(request_of(ACT_TICK, SIDE_LEFT, 8'h55, DIR_LEFT));
        issue(request_of(ACT_TICK, SIDE_LEFT, 8'haa, DIR_UP));
        settle(SETTLE_TICKS);
        // zero sizes act as a single cell
        cfg_write(CFG_GRID_WIDTH, 0);
        cfg_write(CFG_GRID_HEIGHT, 0);
        issue(request_of(ACT_TICK, SIDE_TOP, 8'd255, DIR_DOWN));
        issue(request_of(ACT_TICK, SIDE_TOP, 8'd255, DIR_RIGHT));
        settle(SETTLE_TICKS);

        // ---- long walks on the full grid, sizes above the maximum clamp to it ----
        cfg_write(CFG_GRID_WIDTH, 511);
        cfg_write(CFG_GRID_HEIGHT, 257);
        cfg_write(CFG_CORNERS_MODE, 0);
        cfg_write(CFG_PARTICLE_LIMIT, 6554);
        issue(request_of(ACT_START, SIDE_RIGHT, 8'h3c, DIR_RIGHT));
        // from (128,0) straight down onto the seed at (128,128)
        for (k = 0; k < 128; k++) issue(request_of(ACT_TICK, SIDE_TOP, 8'd128, DIR_DOWN));
        // from (0,128) straight right onto the seed
        for (k = 0; k < 128; k++) issue(request_of(ACT_TICK, SIDE_LEFT, 8'd128, DIR_RIGHT));
        settle(SETTLE_TICKS);

        // ---- random phases: config change, maybe a clearing start, then ticks ----
        starts_left = 4;
        while (live_items < LIVE_TARGET || sb.hits_made < HIT_TARGET) begin
            if ($urandom_range(0, 3) != 0) begin
                size_w = pick_size();
                size_h = pick_size();
                cfg_write(CFG_GRID_WIDTH, size_w);
                cfg_write(CFG_GRID_HEIGHT, size_h);
            end
            if ($urandom_range(0, 1) == 0)
                cfg_write(CFG_CORNERS_MODE, $urandom_range(0, 1));
            if (sb.stuck_total >= sb.cfg_limit && $urandom_range(0, 6) != 0) begin
                // run ended: give it more particles to go on
                lim = sb.stuck_total + $urandom_range(1, 120);
                if (lim > LIMIT_MAX) lim = LIMIT_MAX;
                cfg_write(CFG_PARTICLE_LIMIT, lim);
            end else if ($urandom_range(0, 6) == 0) begin
                case ($urandom_range(0, 3))
                    0:       lim = 0;
                    1:       lim = LIMIT_MAX;
                    2:       lim = $urandom_range(0, LIMIT_MAX);
                    default: lim = sb.stuck_total + 1;
                endcase
                cfg_write(CFG_PARTICLE_LIMIT, lim);
            end
            steady = ($urandom_range(0, 3) == 0);
            if (starts_left != 0 && $urandom_range(0, 5) == 0) begin
                starts_left--;
                issue(request_of(ACT_START, 2'($urandom_range(0, 3)),
                                 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3))));
            end
            // hits are rare on big grids, keep those phases short
            if (sb.used_width() > 40 || sb.used_height() > 40) n = $urandom_range(20, 60);
            else n = $urandom_range(30, 120);
            for (k = 0; k < n; k++) begin
                issue(random_tick());
                // now and then hold off until the block has nothing left to deliver
                if ($urandom_range(0, 39) == 0) settle(0);
            end
            settle(SETTLE_TICKS);
        end

        settle(END_TICKS);
        if (sb.fails == 0 && sb.hits_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
